// ===== rtl/safk_pkg.sv =====
package safk_pkg;

	localparam int LANES = 6;
	localparam int ANGLE_W = 16;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W = 21;
	localparam int XW = 32;
	localparam int ZW = 33;
	localparam int IN_DATA_W = 96;
	localparam int OUT_DATA_W = 88;

	localparam longint PI_Q29 = 64'sd1686629713;
	localparam longint HALF_PI_Q29 = 64'sd843314857;
	localparam longint QUARTER_PI_Q29 = 64'sd421657428;
	localparam longint GAIN_Q29 = 64'sd326016437;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 21'sd524287;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -21'sd524288;
	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_HEIGHT = 3'd0,
		REG_UPPER_ARM   = 3'd1,
		REG_FOREARM     = 3'd2,
		REG_HOME_REACH  = 3'd3
	} cfg_reg_t;

	// atan(2^-i) in q.29 from its power series in q.60
	function automatic longint atan_q29(input int unsigned i);
		longint acc;
		longint term;
		int unsigned k;
		acc = 0;
		if (i == 0) begin
			return QUARTER_PI_Q29;
		end
		for (k = 0; i * (2 * k + 1) <= 59; k++) begin
			term = longint'((64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1));
			if (k[0]) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		return (acc + (64'sd1 <<< 30)) >>> 31;
	endfunction

	localparam longint ATAN_TAB [0:23] = '{
		atan_q29(0), atan_q29(1), atan_q29(2), atan_q29(3), atan_q29(4), atan_q29(5),
		atan_q29(6), atan_q29(7), atan_q29(8), atan_q29(9), atan_q29(10), atan_q29(11),
		atan_q29(12), atan_q29(13), atan_q29(14), atan_q29(15), atan_q29(16), atan_q29(17),
		atan_q29(18), atan_q29(19), atan_q29(20), atan_q29(21), atan_q29(22), atan_q29(23)
	};

endpackage

// ===== rtl/safk_cordic.sv =====
module safk_cordic #(
	parameter int FRAC_BITS = 16,
	parameter int TRIG_ITERATIONS = 16,
	parameter int RW = 19
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic signed [safk_pkg::ANGLE_W-1:0] angle_in [safk_pkg::LANES],
	output logic v_out,
	output logic signed [RW-1:0] sin_out [safk_pkg::LANES],
	output logic signed [RW-1:0] cos_out [safk_pkg::LANES]
);

	localparam int N = TRIG_ITERATIONS;
	localparam int XW = safk_pkg::XW;
	localparam int ZW = safk_pkg::ZW;
	localparam int SHR = 29 - FRAC_BITS;
	localparam logic signed [XW-1:0] GAIN_X = XW'(safk_pkg::GAIN_Q29);
	localparam logic signed [XW-1:0] X_RND = XW'(64'sd1 <<< (28 - FRAC_BITS));
	localparam logic signed [ZW-1:0] HALF_Z = ZW'(safk_pkg::HALF_PI_Q29);
	localparam logic signed [ZW-1:0] PI_Z = ZW'(safk_pkg::PI_Q29);

	logic v_s [0:N];
	logic v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) begin
				v_s[i] <= 1'b0;
			end
			v_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
			for (int i = 0; i < N; i++) begin
				v_s[i+1] <= v_s[i];
			end
			v_q <= v_s[N];
		end
	end

	assign v_out = v_q;

	for (genvar l = 0; l < safk_pkg::LANES; l++) begin : g_lane
		logic signed [XW-1:0] x_s [0:N];
		logic signed [XW-1:0] y_s [0:N];
		logic signed [ZW-1:0] z_s [0:N];
		logic f_s [0:N];
		logic signed [ZW-1:0] z_raw;
		logic signed [XW-1:0] xf;
		logic signed [XW-1:0] yf;
		logic signed [RW-1:0] cos_q;
		logic signed [RW-1:0] sin_q;

		assign z_raw = ZW'(angle_in[l]) <<< 16;
		assign xf = f_s[N] ? -x_s[N] : x_s[N];
		assign yf = f_s[N] ? -y_s[N] : y_s[N];

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0] <= GAIN_X;
				y_s[0] <= '0;
				priority if (z_raw > HALF_Z) begin
					z_s[0] <= z_raw - PI_Z;
					f_s[0] <= 1'b1;
				end else if (z_raw < -HALF_Z) begin
					z_s[0] <= z_raw + PI_Z;
					f_s[0] <= 1'b1;
				end else begin
					z_s[0] <= z_raw;
					f_s[0] <= 1'b0;
				end
				for (int i = 0; i < N; i++) begin
					f_s[i+1] <= f_s[i];
					if (z_s[i] >= 0) begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - ZW'(safk_pkg::ATAN_TAB[i]);
					end else begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + ZW'(safk_pkg::ATAN_TAB[i]);
					end
				end
				cos_q <= RW'((xf + X_RND) >>> SHR);
				sin_q <= RW'((yf + X_RND) >>> SHR);
			end
		end

		assign cos_out[l] = cos_q;
		assign sin_out[l] = sin_q;
	end

endmodule

// ===== rtl/safk_compose.sv =====
module safk_compose #(
	parameter int FRAC_BITS = 16,
	parameter int RW = 19,
	parameter int TW = 23,
	parameter int PASS_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [9*RW+3*TW-1:0] a_in,
	input  logic [9*RW+3*TW-1:0] b_in,
	input  logic [PASS_W-1:0] p_in,
	output logic v_out,
	output logic [9*RW+3*TW-1:0] o_out,
	output logic [PASS_W-1:0] p_out
);

	localparam int RR_W = 2 * RW;
	localparam int RT_W = RW + TW;
	localparam int SR_W = RR_W + 2;
	localparam int ST_W = RT_W + 2;
	localparam logic signed [SR_W-1:0] HALF_R = SR_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ST_W-1:0] HALF_T = ST_W'(1) <<< (FRAC_BITS - 1);

	logic signed [RW-1:0] ar [9];
	logic signed [RW-1:0] br [9];
	logic signed [TW-1:0] at [3];
	logic signed [TW-1:0] bt [3];

	logic signed [RR_W-1:0] rr_s1 [27];
	logic signed [RT_W-1:0] rt_s1 [9];
	logic signed [TW-1:0] at_s1 [3];
	logic [PASS_W-1:0] p_s1;
	logic v_s1;

	logic signed [SR_W-1:0] sr [9];
	logic signed [ST_W-1:0] st [3];

	logic signed [RW-1:0] or_s2 [9];
	logic signed [TW-1:0] ot_s2 [3];
	logic [PASS_W-1:0] p_s2;
	logic v_s2;

	for (genvar e = 0; e < 9; e++) begin : g_unr
		assign ar[e] = a_in[e*RW +: RW];
		assign br[e] = b_in[e*RW +: RW];
		assign o_out[e*RW +: RW] = or_s2[e];
	end

	for (genvar e = 0; e < 3; e++) begin : g_unt
		assign at[e] = a_in[9*RW + e*TW +: TW];
		assign bt[e] = b_in[9*RW + e*TW +: TW];
		assign o_out[9*RW + e*TW +: TW] = ot_s2[e];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					for (int j = 0; j < 3; j++) begin
						rr_s1[(i*3+j)*3+k] <= ar[i*3+k] * br[k*3+j];
					end
					rt_s1[i*3+k] <= ar[i*3+k] * bt[k];
				end
				at_s1[i] <= at[i];
			end
			p_s1 <= p_in;
		end
	end

	always_comb begin
		for (int e = 0; e < 9; e++) begin
			sr[e] = SR_W'(rr_s1[e*3]) + SR_W'(rr_s1[e*3+1]) + SR_W'(rr_s1[e*3+2]) + HALF_R;
		end
		for (int i = 0; i < 3; i++) begin
			st[i] = ST_W'(rt_s1[i*3]) + ST_W'(rt_s1[i*3+1]) + ST_W'(rt_s1[i*3+2]) + HALF_T;
		end
	end

	// sums, rounded half up
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 9; e++) begin
				or_s2[e] <= RW'(sr[e] >>> FRAC_BITS);
			end
			for (int i = 0; i < 3; i++) begin
				ot_s2[i] <= TW'(st[i] >>> FRAC_BITS) + at_s1[i];
			end
			p_s2 <= p_s1;
		end
	end

	assign v_out = v_s2;
	assign p_out = p_s2;

endmodule

// ===== rtl/six_axis_forward_kinematics_core.sv =====
// an accepted pose passes the CORDIC, joint transforms and compose chain to the
//   four-row output serialiser, which sends one row per cycle while m_axis_tready
//   is high; new poses enter unless a finished pose waits for the busy serialiser
// reset: valid bits cleared, link registers back to their defaults
module six_axis_forward_kinematics_core #(
	parameter int FRAC_BITS = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// joint1_angle, joint2_angle, .. joint6_angle, 16 bits each
	input  logic [safk_pkg::IN_DATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// row_index, col0_value, col1_value, col2_value, col3_value, zero pad
	output logic [safk_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [safk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [safk_pkg::CFG_W-1:0] cfg_data
);

	localparam int LANES = safk_pkg::LANES;
	localparam int OUT_W = safk_pkg::OUT_W;
	localparam int RW = FRAC_BITS + 3;
	localparam int TW = FRAC_BITS + 7;
	localparam int HW = FRAC_BITS + 4;
	localparam int FRW = 9 * RW + 3 * TW;
	localparam int PASSW = 4 * FRW;
	localparam int PH_W = RW + HW + 1;
	localparam int EXTW = FRAC_BITS + 24;
	localparam int UP = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
	localparam int DN = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);
	localparam int TF_RND = (1 << DN) >> 1;
	localparam int EW = ((TW > OUT_W) ? TW : OUT_W) + 1;
	localparam logic [LANES-1:0] AXIS_Y = 6'b010110;
	localparam logic signed [RW-1:0] ONE_R = RW'(1) <<< FRAC_BITS;
	localparam logic signed [PH_W-1:0] PH_HALF = PH_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [OUT_W-1:0] ONE_OUT =
		((64'sd1 <<< FRAC_BITS) > 64'sd524287) ? safk_pkg::OUT_MAX : OUT_W'(1 << FRAC_BITS);

	// link registers
	logic [safk_pkg::CFG_W-1:0] base_q;
	logic [safk_pkg::CFG_W-1:0] upper_q;
	logic [safk_pkg::CFG_W-1:0] fore_q;
	logic [safk_pkg::CFG_W-1:0] reach_q;
	logic [HW-1:0] h1_q;
	logic [HW-1:0] h2_q;
	logic [HW-1:0] h4_q;
	logic [HW-1:0] hr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 17'd32178;
			upper_q <= 17'd29491;
			fore_q <= 17'd29491;
			reach_q <= 17'd96666;
		end else if (cfg_valid && cfg_ready) begin
			unique case (safk_pkg::cfg_reg_t'(cfg_index))
				safk_pkg::REG_BASE_HEIGHT: base_q <= cfg_data;
				safk_pkg::REG_UPPER_ARM:   upper_q <= cfg_data;
				safk_pkg::REG_FOREARM:     fore_q <= cfg_data;
				safk_pkg::REG_HOME_REACH:  reach_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [HW-1:0] to_frac(input logic [EXTW-1:0] v);
		return HW'(((v + EXTW'(TF_RND)) >> DN) << UP);
	endfunction

	always_ff @(posedge clk) begin
		h1_q <= to_frac(EXTW'(base_q));
		h2_q <= to_frac(EXTW'(base_q) + EXTW'(upper_q));
		h4_q <= to_frac(EXTW'(base_q) + EXTW'(upper_q) + EXTW'(fore_q));
		hr_q <= to_frac(EXTW'(reach_q));
	end

	// pipeline control
	logic en;
	logic v_fin;
	logic ser_v_q;
	logic [1:0] row_q;
	logic ser_free;
	logic ser_load;

	assign ser_free = !ser_v_q || (m_axis_tready && row_q == safk_pkg::ROW_LAST);
	assign en = ser_free || !v_fin;
	assign ser_load = v_fin && ser_free;
	assign s_axis_tready = en;

	// sine and cosine
	logic signed [safk_pkg::ANGLE_W-1:0] angle [LANES];
	logic signed [RW-1:0] sin_w [LANES];
	logic signed [RW-1:0] cos_w [LANES];
	logic v_cor;

	for (genvar l = 0; l < LANES; l++) begin : g_ang
		assign angle[l] = s_axis_tdata[l*safk_pkg::ANGLE_W +: safk_pkg::ANGLE_W];
	end

	safk_cordic #(
		.FRAC_BITS(FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS),
		.RW(RW)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.v_in(s_axis_tvalid && s_axis_tready),
		.angle_in(angle),
		.v_out(v_cor),
		.sin_out(sin_w),
		.cos_out(cos_w)
	);

	// joint transforms
	logic [HW-1:0] h_lane [LANES];
	logic signed [RW-1:0] s_s1 [LANES];
	logic signed [RW-1:0] c_s1 [LANES];
	logic signed [PH_W-1:0] sh_s1 [LANES];
	logic signed [PH_W-1:0] ch_s1 [LANES];
	logic v_s1;
	logic [FRW-1:0] jf_c [LANES];
	logic [FRW-1:0] jf_s2 [LANES];
	logic v_s2;

	assign h_lane[0] = '0;
	assign h_lane[1] = h1_q;
	assign h_lane[2] = h2_q;
	assign h_lane[3] = '0;
	assign h_lane[4] = h4_q;
	assign h_lane[5] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_cor;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				s_s1[l] <= sin_w[l];
				c_s1[l] <= cos_w[l];
				sh_s1[l] <= sin_w[l] * $signed({1'b0, h_lane[l]});
				ch_s1[l] <= cos_w[l] * $signed({1'b0, h_lane[l]});
				jf_s2[l] <= jf_c[l];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_jf
		if (AXIS_Y[l]) begin : g_y
			logic signed [PH_W-1:0] shr;
			logic signed [PH_W-1:0] chr;
			logic signed [TW-1:0] tx;
			logic signed [TW-1:0] tz;
			assign shr = (sh_s1[l] + PH_HALF) >>> FRAC_BITS;
			assign chr = (ch_s1[l] + PH_HALF) >>> FRAC_BITS;
			assign tx = -TW'(shr);
			assign tz = TW'(h_lane[l]) - TW'(chr);
			assign jf_c[l] = {tz, TW'(0), tx, c_s1[l], RW'(0), -s_s1[l], RW'(0), ONE_R,
				RW'(0), s_s1[l], RW'(0), c_s1[l]};
		end else begin : g_z
			assign jf_c[l] = {TW'(0), TW'(0), TW'(0), ONE_R, RW'(0), RW'(0), RW'(0),
				c_s1[l], s_s1[l], RW'(0), -s_s1[l], c_s1[l]};
		end
	end

	// product chain, home pose last
	logic [FRW-1:0] home_frame;
	logic [FRW-1:0] acc_w [0:6];
	logic v_w [0:6];
	logic [PASSW-1:0] pass_w [1:4];

	assign home_frame = {TW'(hr_q), TW'(0), TW'(0), ONE_R, RW'(0), RW'(0), RW'(0), -ONE_R,
		RW'(0), RW'(0), RW'(0), -ONE_R};
	assign acc_w[0] = jf_s2[0];
	assign v_w[0] = v_s2;

	for (genvar k = 0; k < 6; k++) begin : g_comp
		logic [FRW-1:0] b_k;
		logic [PASSW-1:0] p_k;
		if (k == 0) begin : g_first
			assign b_k = jf_s2[1];
			assign p_k = {jf_s2[5], jf_s2[4], jf_s2[3], jf_s2[2]};
		end else if (k < 5) begin : g_mid
			assign b_k = pass_w[k][FRW-1:0];
			assign p_k = pass_w[k] >> FRW;
		end else begin : g_home
			assign b_k = home_frame;
			assign p_k = '0;
		end
		if (k < 4) begin : g_pass
			safk_compose #(
				.FRAC_BITS(FRAC_BITS), .RW(RW), .TW(TW), .PASS_W(PASSW)
			) u_comp (
				.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_w[k]),
				.a_in(acc_w[k]), .b_in(b_k), .p_in(p_k),
				.v_out(v_w[k+1]), .o_out(acc_w[k+1]), .p_out(pass_w[k+1])
			);
		end else begin : g_nopass
			safk_compose #(
				.FRAC_BITS(FRAC_BITS), .RW(RW), .TW(TW), .PASS_W(PASSW)
			) u_comp (
				.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_w[k]),
				.a_in(acc_w[k]), .b_in(b_k), .p_in(p_k),
				.v_out(v_w[k+1]), .o_out(acc_w[k+1]), .p_out()
			);
		end
	end

	assign v_fin = v_w[6];

	// output serialiser
	function automatic logic signed [OUT_W-1:0] sat(input logic signed [EW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > EW'(safk_pkg::OUT_MAX)) begin
			r = safk_pkg::OUT_MAX;
		end else if (v < EW'(safk_pkg::OUT_MIN)) begin
			r = safk_pkg::OUT_MIN;
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

	logic signed [OUT_W-1:0] pose_q [3][4];
	logic signed [OUT_W-1:0] col [4];

	always_ff @(posedge clk) begin
		if (ser_load) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pose_q[i][j] <= sat(EW'($signed(acc_w[6][(i*3+j)*RW +: RW])));
				end
				pose_q[i][3] <= sat(EW'($signed(acc_w[6][9*RW + i*TW +: TW])));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			row_q <= '0;
		end else if (ser_load) begin
			ser_v_q <= 1'b1;
			row_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			row_q <= row_q + 2'd1;
			if (row_q == safk_pkg::ROW_LAST) begin
				ser_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (row_q)
			2'd0: col = pose_q[0];
			2'd1: col = pose_q[1];
			2'd2: col = pose_q[2];
			default: col = '{OUT_W'(0), OUT_W'(0), OUT_W'(0), ONE_OUT};
		endcase
	end

	assign m_axis_tvalid = ser_v_q;
	assign m_axis_tlast = (row_q == safk_pkg::ROW_LAST);
	assign m_axis_tdata = {2'b00, col[3], col[2], col[1], col[0], row_q};

`ifndef SYNTH
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && row_q != safk_pkg::ROW_LAST)
		|=> (m_axis_tvalid && row_q == $past(row_q) + 2'd1))
		else $error("row sequence broken");
	a_load_row0: assert property (@(posedge clk) disable iff (!arst_n)
		ser_load |=> (m_axis_tvalid && row_q == 2'd0))
		else $error("pose load not at first row");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast && !ser_load) |=> !m_axis_tvalid)
		else $error("serialiser did not empty");
`endif

endmodule
